// ===== rtl/dspf_pkg.sv =====
`timescale 1ns / 1ps

package dspf_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned QFracW    = 16;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned CfgIdxW   = 3;

  // Input register, products, sums, square root, divider set-up, first divider,
  // rate clamp, gain products, scalar sum, offset products, set-up, second
  // dividers and the output register.
  localparam int unsigned Latency = 3 + SqrtSteps + 1 + DivSteps + 5 + DivSteps + 1;

  localparam logic [CfgIdxW-1:0] RegAnchorX     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAnchorY     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRestLength  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpringGain  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDampingGain = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPullEnable  = 3'd5;

endpackage

// ===== rtl/dspf_div.sv =====
`timescale 1ns / 1ps

module dspf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [2*dspf_pkg::DataW-1:0] num_i,
  input  logic [dspf_pkg::DataW-1:0]   den_i,
  output logic                        valid_o,
  output logic [dspf_pkg::DataW-1:0]   quo_o
);
  import dspf_pkg::*;

  // The upper half of the numerator must be below the divisor.
  logic [DivSteps-1:0] v_q;
  logic [DataW-1:0]    rem_q [DivSteps];
  logic [DataW-1:0]    low_q [DivSteps];
  logic [DataW-1:0]    quo_q [DivSteps];
  logic [DataW-1:0]    den_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic             v_in;
    logic [DataW-1:0] rem_in;
    logic [DataW-1:0] low_in;
    logic [DataW-1:0] quo_in;
    logic [DataW-1:0] den_in;
    logic [DataW:0]   t;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_i[2*DataW-1:DataW];
      assign low_in = num_i[DataW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
    end

    assign t  = {rem_in, low_in[DataW-1]};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? DataW'(t - {1'b0, den_in}) : t[DataW-1:0];
      low_q[i] <= {low_in[DataW-2:0], 1'b0};
      quo_q[i] <= {quo_in[DataW-2:0], ge};
      den_q[i] <= den_in;
    end
  end

  assign valid_o = v_q[DivSteps-1];
  assign quo_o   = quo_q[DivSteps-1];

endmodule

// ===== rtl/damped_spring_pull_force_core.sv =====
`timescale 1ns / 1ps

// Damped spring pull on one 2D body per word, signed Q16.16 throughout.
// A body word is taken at every rising edge at which start is high; busy
// stays low, so a new word may follow in every cycle.
// Each result word appears on force_x_out_o, force_y_out_o and
// zero_distance_o for exactly one cycle, marked by valid_o, in the order
// the bodies came in.
// The latency comes mostly from the 32-stage square root and the 32-stage
// dividers, one for the damping rate and one pair for the force direction.
// The receiver cannot stall the block, so results are never held back.
// Configuration words come over their own channel (cfg_valid_i, always
// ready) and should be written only while no body is in flight.
// Writes to an unknown register index are ignored.
// Reset clears all configuration registers, so pulling is disabled, and
// empties the pipeline; bodies in flight at reset are lost.
module damped_spring_pull_force_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [dspf_pkg::DataW-1:0]    pos_x_i,
  input  logic signed [dspf_pkg::DataW-1:0]    pos_y_i,
  input  logic signed [dspf_pkg::DataW-1:0]    vel_x_i,
  input  logic signed [dspf_pkg::DataW-1:0]    vel_y_i,
  input  logic signed [dspf_pkg::DataW-1:0]    force_x_in_i,
  input  logic signed [dspf_pkg::DataW-1:0]    force_y_in_i,
  output logic                                 valid_o,
  output logic signed [dspf_pkg::DataW-1:0]    force_x_out_o,
  output logic signed [dspf_pkg::DataW-1:0]    force_y_out_o,
  output logic                                 zero_distance_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dspf_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [dspf_pkg::DataW-1:0]           cfg_data_i
);
  import dspf_pkg::*;

  localparam int unsigned WideW = 2 * DataW;

  typedef struct packed {
    logic signed [WideW-1:0] dot;
    logic signed [DataW-1:0] dx;
    logic signed [DataW-1:0] dy;
    logic signed [DataW-1:0] fx;
    logic signed [DataW-1:0] fy;
    logic                    en;
  } sqrt_side_t;

  typedef struct packed {
    logic signed [DataW-1:0] e;
    logic signed [DataW-1:0] dx;
    logic signed [DataW-1:0] dy;
    logic signed [DataW-1:0] fx;
    logic signed [DataW-1:0] fy;
    logic [DataW-1:0]        den;
    logic                    zero;
    logic                    en;
    logic                    neg;
    logic                    ovf;
  } div1_side_t;

  typedef struct packed {
    logic signed [DataW-1:0] fx;
    logic signed [DataW-1:0] fy;
    logic                    zero;
    logic                    en;
    logic                    negx;
    logic                    negy;
    logic                    ovfx;
    logic                    ovfy;
  } div2_side_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW+1:0] v);
    if (v > (WideW+2)'(64'sd2147483647)) begin
      return 32'sh7fff_ffff;
    end else if (v < (WideW+2)'(-64'sd2147483648)) begin
      return 32'sh8000_0000;
    end
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [WideW-QFracW-1:0] trunc_q(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] b;
    b = x + (x[WideW-1] ? WideW'((1 << QFracW) - 1) : WideW'(0));
    return b[WideW-1:QFracW];
  endfunction

  // Configuration registers
  logic signed [DataW-1:0] anchor_x_q, anchor_y_q, spring_gain_q, damping_gain_q;
  logic [DataW-2:0]        rest_length_q;
  logic                    pull_enable_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_x_q     <= '0;
      anchor_y_q     <= '0;
      rest_length_q  <= '0;
      spring_gain_q  <= '0;
      damping_gain_q <= '0;
      pull_enable_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegAnchorX:     anchor_x_q     <= cfg_data_i;
        RegAnchorY:     anchor_y_q     <= cfg_data_i;
        RegRestLength:  rest_length_q  <= cfg_data_i[DataW-2:0];
        RegSpringGain:  spring_gain_q  <= cfg_data_i;
        RegDampingGain: damping_gain_q <= cfg_data_i;
        RegPullEnable:  pull_enable_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage 1: offsets
  logic                    v1_q;
  logic signed [DataW-1:0] dx1_q, dy1_q, vx1_q, vy1_q, fx1_q, fy1_q;
  logic                    en1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= sat32((WideW+2)'(pos_x_i) - (WideW+2)'(anchor_x_q));
    dy1_q <= sat32((WideW+2)'(pos_y_i) - (WideW+2)'(anchor_y_q));
    vx1_q <= vel_x_i;
    vy1_q <= vel_y_i;
    fx1_q <= force_x_in_i;
    fy1_q <= force_y_in_i;
    en1_q <= pull_enable_q;
  end

  // Stage 2: products
  logic                    v2_q;
  logic signed [WideW-1:0] mxx2_q, myy2_q, pxv2_q, pyv2_q;
  logic signed [DataW-1:0] dx2_q, dy2_q, fx2_q, fy2_q;
  logic                    en2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mxx2_q <= WideW'(dx1_q) * WideW'(dx1_q);
    myy2_q <= WideW'(dy1_q) * WideW'(dy1_q);
    pxv2_q <= WideW'(dx1_q) * WideW'(vx1_q);
    pyv2_q <= WideW'(dy1_q) * WideW'(vy1_q);
    dx2_q  <= dx1_q;
    dy2_q  <= dy1_q;
    fx2_q  <= fx1_q;
    fy2_q  <= fy1_q;
    en2_q  <= en1_q;
  end

  // Stage 3: squared distance and dot product
  logic                  v3_q;
  logic [WideW-1:0]      sq3_q;
  sqrt_side_t            side3_q;
  logic signed [WideW:0] dot_sum;

  assign dot_sum = (WideW+1)'(pxv2_q) + (WideW+1)'(pyv2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq3_q <= WideW'(mxx2_q) + WideW'(myy2_q);
    if (dot_sum[WideW] != dot_sum[WideW-1]) begin
      side3_q.dot <= dot_sum[WideW] ? {1'b1, {(WideW-1){1'b0}}} : {1'b0, {(WideW-1){1'b1}}};
    end else begin
      side3_q.dot <= dot_sum[WideW-1:0];
    end
    side3_q.dx <= dx2_q;
    side3_q.dy <= dy2_q;
    side3_q.fx <= fx2_q;
    side3_q.fy <= fy2_q;
    side3_q.en <= en2_q;
  end

  // Square root, one result bit per stage
  logic [SqrtSteps-1:0] sv_q;
  logic [WideW-1:0]     rad_q  [SqrtSteps];
  logic [DataW+1:0]     srem_q [SqrtSteps];
  logic [DataW-1:0]     root_q [SqrtSteps];
  sqrt_side_t           sside_q [SqrtSteps];

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic             v_in;
    logic [WideW-1:0] rad_in;
    logic [DataW+1:0] rem_in;
    logic [DataW-1:0] root_in;
    sqrt_side_t       side_in;
    logic [DataW+3:0] t;
    logic [DataW+3:0] trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_in    = v3_q;
      assign rad_in  = sq3_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side3_q;
    end else begin : g_next
      assign v_in    = sv_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = srem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = sside_q[i-1];
    end

    assign t     = {rem_in, rad_in[WideW-1:WideW-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i] <= 1'b0;
      end else begin
        sv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i]   <= {rad_in[WideW-3:0], 2'b00};
      srem_q[i]  <= ge ? (DataW+2)'(t - trial) : t[DataW+1:0];
      root_q[i]  <= {root_in[DataW-2:0], ge};
      sside_q[i] <= side_in;
    end
  end

  // Stage E: divider set-up for the damping rate
  logic                    ve_q;
  logic [WideW-1:0]        num_e_q;
  div1_side_t              side_e_q;
  logic [DataW-1:0]        d_root;
  sqrt_side_t              sq_out;
  logic [WideW-1:0]        dot_abs;
  logic [DataW-1:0]        den_e;

  assign d_root  = root_q[SqrtSteps-1];
  assign sq_out  = sside_q[SqrtSteps-1];
  assign dot_abs = sq_out.dot[WideW-1] ? WideW'(-sq_out.dot) : WideW'(sq_out.dot);
  assign den_e   = (d_root == '0) ? DataW'(1) : d_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= sv_q[SqrtSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    num_e_q       <= dot_abs;
    side_e_q.e    <= sat32((WideW+2)'(d_root) - (WideW+2)'(rest_length_q));
    side_e_q.dx   <= sq_out.dx;
    side_e_q.dy   <= sq_out.dy;
    side_e_q.fx   <= sq_out.fx;
    side_e_q.fy   <= sq_out.fy;
    side_e_q.den  <= den_e;
    side_e_q.zero <= sq_out.en && (d_root == '0);
    side_e_q.en   <= sq_out.en;
    side_e_q.neg  <= sq_out.dot[WideW-1];
    side_e_q.ovf  <= dot_abs[WideW-1:DataW] >= den_e;
  end

  logic             div1_v;
  logic [DataW-1:0] div1_q;
  div1_side_t       dly1_q [DivSteps];

  dspf_div u_div_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ve_q),
    .num_i   (num_e_q),
    .den_i   (side_e_q.den),
    .valid_o (div1_v),
    .quo_o   (div1_q)
  );

  always_ff @(posedge clk_i) begin
    dly1_q[0] <= side_e_q;
    for (int i = 1; i < DivSteps; i++) begin
      dly1_q[i] <= dly1_q[i-1];
    end
  end

  // Stage F: clamp the damping rate
  logic                    vf_q;
  logic signed [DataW-1:0] r_f_q;
  div1_side_t              side_f_q;
  div1_side_t              s1_out;

  assign s1_out = dly1_q[DivSteps-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= div1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!s1_out.neg) begin
      r_f_q <= (s1_out.ovf || div1_q[DataW-1]) ? 32'sh7fff_ffff : div1_q;
    end else begin
      r_f_q <= (s1_out.ovf || div1_q > 32'h8000_0000) ? 32'sh8000_0000 : -div1_q;
    end
    side_f_q <= s1_out;
  end

  // Stage G: gain products
  logic                    vg_q;
  logic signed [WideW-1:0] pe_g_q, pr_g_q;
  div1_side_t              side_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else begin
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pe_g_q   <= WideW'(spring_gain_q) * WideW'(side_f_q.e);
    pr_g_q   <= WideW'(damping_gain_q) * WideW'(r_f_q);
    side_g_q <= side_f_q;
  end

  // Stage H: scalar pull
  logic                    vh_q;
  logic signed [DataW-1:0] s_h_q;
  div1_side_t              side_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
    end else begin
      vh_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_h_q    <= sat32((WideW+2)'(trunc_q(pe_g_q)) + (WideW+2)'(trunc_q(pr_g_q)));
    side_h_q <= side_g_q;
  end

  // Stage I: scalar times offset
  logic                    vi_q;
  logic signed [WideW-1:0] nx_i_q, ny_i_q;
  div1_side_t              side_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= 1'b0;
    end else begin
      vi_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_i_q   <= WideW'(s_h_q) * WideW'(side_h_q.dx);
    ny_i_q   <= WideW'(s_h_q) * WideW'(side_h_q.dy);
    side_i_q <= side_h_q;
  end

  // Stage J: divider set-up for the force direction
  logic             vj_q;
  logic [WideW-1:0] numx_j_q, numy_j_q;
  logic [DataW-1:0] den_j_q;
  div2_side_t       side_j_q;
  logic [WideW-1:0] nx_abs, ny_abs;

  assign nx_abs = nx_i_q[WideW-1] ? WideW'(-nx_i_q) : WideW'(nx_i_q);
  assign ny_abs = ny_i_q[WideW-1] ? WideW'(-ny_i_q) : WideW'(ny_i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vj_q <= 1'b0;
    end else begin
      vj_q <= vi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    numx_j_q      <= nx_abs;
    numy_j_q      <= ny_abs;
    den_j_q       <= side_i_q.den;
    side_j_q.fx   <= side_i_q.fx;
    side_j_q.fy   <= side_i_q.fy;
    side_j_q.zero <= side_i_q.zero;
    side_j_q.en   <= side_i_q.en;
    side_j_q.negx <= nx_i_q[WideW-1];
    side_j_q.negy <= ny_i_q[WideW-1];
    side_j_q.ovfx <= nx_abs[WideW-1:DataW] >= side_i_q.den;
    side_j_q.ovfy <= ny_abs[WideW-1:DataW] >= side_i_q.den;
  end

  logic             divx_v, divy_v;
  logic [DataW-1:0] divx_q, divy_q;
  div2_side_t       dly2_q [DivSteps];

  dspf_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vj_q),
    .num_i   (numx_j_q),
    .den_i   (den_j_q),
    .valid_o (divx_v),
    .quo_o   (divx_q)
  );

  dspf_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vj_q),
    .num_i   (numy_j_q),
    .den_i   (den_j_q),
    .valid_o (divy_v),
    .quo_o   (divy_q)
  );

  always_ff @(posedge clk_i) begin
    dly2_q[0] <= side_j_q;
    for (int i = 1; i < DivSteps; i++) begin
      dly2_q[i] <= dly2_q[i-1];
    end
  end

  // Stage K: force update
  div2_side_t              s2_out;
  logic [DataW:0]          magx, magy;
  logic signed [DataW+1:0] qx, qy;
  logic                    out_v_q;
  logic signed [DataW-1:0] fx_out_q, fy_out_q;
  logic                    zero_out_q;

  assign s2_out = dly2_q[DivSteps-1];
  assign magx   = s2_out.ovfx ? {1'b1, {DataW{1'b0}}} : {1'b0, divx_q};
  assign magy   = s2_out.ovfy ? {1'b1, {DataW{1'b0}}} : {1'b0, divy_q};
  assign qx     = s2_out.negx ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
  assign qy     = s2_out.negy ? -$signed({1'b0, magy}) : $signed({1'b0, magy});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= divx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!s2_out.en || s2_out.zero) begin
      fx_out_q <= s2_out.fx;
      fy_out_q <= s2_out.fy;
    end else begin
      fx_out_q <= sat32((WideW+2)'(s2_out.fx) - (WideW+2)'(qx));
      fy_out_q <= sat32((WideW+2)'(s2_out.fy) - (WideW+2)'(qy));
    end
    zero_out_q <= s2_out.zero;
  end

  assign valid_o         = out_v_q;
  assign force_x_out_o   = fx_out_q;
  assign force_y_out_o   = fy_out_q;
  assign zero_distance_o = zero_out_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency valid_o)
    else $error("Result word missing after the pipeline latency.");

  a_dividers_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divx_v == divy_v)
    else $error("Force direction dividers out of step.");

  a_zero_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ve_q && side_e_q.zero |-> side_e_q.en && side_e_q.den == DataW'(1))
    else $error("Zero distance flagged while pulling is disabled.");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dspf_pkg::*;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               zd;
  } force_word_t;

  typedef enum logic { RowBody, RowReg } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [2:0]         idx;
    logic [31:0]        data;
    logic signed [31:0] px, py, vx, vy, fx, fy;
    logic               typed;
    force_word_t        want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic signed [31:0] force_x_in_i = '0, force_y_in_i = '0;
  logic valid_o;
  logic signed [31:0] force_x_out_o, force_y_out_o;
  logic zero_distance_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  logic        row_typed = 1'b0;
  force_word_t row_want = '0;

  longint ax, ay, rest, ks, kd;
  logic   pull_on;

  force_word_t pending_forces[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  damped_spring_pull_force_core dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic force_word_t pull_force(longint px, longint py, longint vx,
                                             longint vy, longint fx, longint fy);
    force_word_t w;
    longint dx, dy, d, p1, p2, dot, e, r, s;
    logic [63:0] sq;
    w.fx = fx[31:0];
    w.fy = fy[31:0];
    w.zd = 1'b0;
    if (!pull_on) return w;
    dx = clamp32(px - ax);
    dy = clamp32(py - ay);
    sq = 64'(dx * dx) + 64'(dy * dy);
    d = longint'(floor_sqrt(sq));
    if (d == 0) begin
      w.zd = 1'b1;
      return w;
    end
    p1 = dx * vx;
    p2 = dy * vy;
    if (p1 > 0 && p2 > 64'sh7fffffffffffffff - p1) dot = 64'sh7fffffffffffffff;
    else if (p1 < 0 && p2 < -64'sh7fffffffffffffff - 1 - p1) dot = 64'sh8000000000000000;
    else dot = p1 + p2;
    e = clamp32(d - rest);
    r = clamp32(dot / d);
    s = clamp32((ks * e) / 65536 + (kd * r) / 65536);
    w.fx = clamp32(fx - (s * dx) / d);
    w.fy = clamp32(fy - (s * dy) / d);
    return w;
  endfunction

  always @(posedge clk_i) begin
    force_word_t got, exp_w;
    logic        seen;
    got = {force_x_out_o, force_y_out_o, zero_distance_o};
    seen = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        seen = 1'b1;
        if (row_typed) pending_forces.push_back(row_want);
        else pending_forces.push_back(pull_force(pos_x_i, pos_y_i, vel_x_i, vel_y_i,
                                                 force_x_in_i, force_y_in_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        seen = 1'b1;
        case (cfg_index_i)
          RegAnchorX:     ax = longint'($signed(cfg_data_i));
          RegAnchorY:     ay = longint'($signed(cfg_data_i));
          RegRestLength:  rest = longint'({33'd0, cfg_data_i[30:0]});
          RegSpringGain:  ks = longint'($signed(cfg_data_i));
          RegDampingGain: kd = longint'($signed(cfg_data_i));
          RegPullEnable:  pull_on = cfg_data_i[0];
          default: ;
        endcase
      end
      if (valid_o) begin
        seen = 1'b1;
        if (pending_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_w = pending_forces.pop_front();
          if (got.fx !== exp_w.fx || got.fy !== exp_w.fy || got.zd !== exp_w.zd) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: fx %h/%h fy %h/%h zd %b/%b (expected/actual)",
                       exp_w.fx, got.fx, exp_w.fy, got.fy, exp_w.zd, got.zd);
          end
        end
      end
    end
    idle_cycles <= seen ? 0 : idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 4000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_body(row_t rw, bit gaps);
    start <= 1'b1;
    pos_x_i <= rw.px; pos_y_i <= rw.py;
    vel_x_i <= rw.vx; vel_y_i <= rw.vy;
    force_x_in_i <= rw.fx; force_y_in_i <= rw.fy;
    row_typed <= rw.typed;
    row_want <= rw.want;
    do @(posedge clk_i); while (busy);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_forces.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic row_t body(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                                logic [31:0] vy, logic [31:0] fx, logic [31:0] fy,
                                logic typed, logic zd);
    row_t rw;
    rw = '{kind: RowBody, idx: '0, data: '0, px: px, py: py, vx: vx, vy: vy,
           fx: fx, fy: fy, typed: typed, want: '{fx: fx, fy: fy, zd: zd}};
    return rw;
  endfunction

  function automatic row_t reg_row(logic [2:0] idx, logic [31:0] data);
    row_t rw;
    rw = body('0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
    rw.kind = RowReg;
    rw.idx = idx;
    rw.data = data;
    return rw;
  endfunction

  function automatic logic [31:0] near(logic [31:0] c);
    return c + 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    row_t dir[$];
    row_t rw;
    logic [31:0] cx, cy;
    ax = 0; ay = 0; rest = 0; ks = 0; kd = 0; pull_on = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir.push_back(body(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0));
    dir.push_back(body(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                       32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0));
    dir.push_back(body('0, '0, '0, '0, 32'h1234_5678, 32'hfedc_ba98, 1'b1, 1'b0));
    dir.push_back(reg_row(RegPullEnable, 32'd1));
    dir.push_back(body('0, '0, 32'h0001_0000, 32'h8000_0000,
                       32'h0bad_f00d, 32'h8000_0000, 1'b1, 1'b1));
    dir.push_back(reg_row(RegSpringGain, 32'h0001_0000));
    dir.push_back(reg_row(RegDampingGain, 32'h0000_8000));
    dir.push_back(reg_row(RegRestLength, 32'h0002_0000));
    dir.push_back(body(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, '0, '0, '0, 1'b0, 1'b0));
    dir.push_back(body(32'hffff_0000, '0, '0, 32'h0001_0000, 32'h7fff_ffff, '0, 1'b0, 1'b0));
    dir.push_back(body('0, '0, 32'h7fff_ffff, '0, '0, '0, 1'b1, 1'b1));
    dir.push_back(reg_row(RegAnchorX, 32'h7fff_ffff));
    dir.push_back(reg_row(RegAnchorY, 32'h8000_0000));
    dir.push_back(body(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0));
    dir.push_back(body(32'h7fff_ffff, 32'h8000_0000, '0, '0, '0, '0, 1'b1, 1'b1));
    dir.push_back(reg_row(RegSpringGain, 32'h8000_0000));
    dir.push_back(reg_row(RegDampingGain, 32'h7fff_ffff));
    dir.push_back(reg_row(RegRestLength, 32'hffff_ffff));
    dir.push_back(reg_row(3'd6, 32'hffff_ffff));
    dir.push_back(reg_row(3'd7, 32'h0000_0000));
    dir.push_back(body(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0));
    dir.push_back(body(32'h7fff_0000, 32'h8001_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                       '0, '0, 1'b0, 1'b0));
    dir.push_back(reg_row(RegPullEnable, 32'hffff_fffe));
    dir.push_back(body(32'h0123_4567, 32'h89ab_cdef, '0, '0,
                       32'h5555_aaaa, 32'haaaa_5555, 1'b1, 1'b0));

    foreach (dir[i]) begin
      if (dir[i].kind == RowReg) begin
        drain();
        write_reg(dir[i].idx, dir[i].data);
      end else begin
        send_body(dir[i], 1'b1);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      cx = pick_value();
      cy = pick_value();
      write_reg(RegAnchorX, cx);
      write_reg(RegAnchorY, cy);
      write_reg(RegRestLength, (ph == 2) ? 32'h7fff_ffff : (ph == 3) ? 32'h0 :
                $urandom_range(0, 32'h000f_ffff) | ($urandom & 32'h8000_0000));
      write_reg(RegSpringGain, (ph == 2) ? 32'h7fff_ffff : (ph == 3) ? 32'h8000_0000 :
                pick_value());
      write_reg(RegDampingGain, (ph == 2) ? 32'h8000_0000 : (ph == 3) ? 32'h7fff_ffff :
                pick_value());
      write_reg(RegPullEnable, (ph == 5) ? 32'h0 : ($urandom | 32'd1));
      write_reg(3'($urandom_range(6, 7)), $urandom);
      for (int n = 0; n < 160; n++) begin
        rw = body(0, 0, 0, 0, $urandom, $urandom, 1'b0, 1'b0);
        case ($urandom_range(0, 9))
          0: begin rw.px = $urandom; rw.py = $urandom; end
          1: begin rw.px = cx; rw.py = cy; end
          default: begin rw.px = near(cx); rw.py = near(cy); end
        endcase
        if ($urandom_range(0, 2) == 0) begin
          rw.vx = $urandom; rw.vy = $urandom;
        end else begin
          rw.vx = near(0); rw.vy = near(0);
        end
        if ($urandom_range(0, 1)) begin
          rw.fx = near(0); rw.fy = near(0);
        end
        send_body(rw, ph < 7 && (n % 64) < 40);
      end
    end

    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_forces.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dspf_pkg.sv
rtl/dspf_div.sv
rtl/damped_spring_pull_force_core.sv
sim/tb_top.sv
